// ===== design/rsfp_pkg.sv =====
// package: types, codes and defaults for the range sensor frame parser
`timescale 1ns / 1ps

package rsfp_pkg;

    localparam int unsigned READINGS_DEF              = 91;
    localparam int unsigned DATA_HEADER_BYTES_DEF     = 4;
    localparam int unsigned CONNECT_PAYLOAD_BYTES_DEF = 5;

    localparam int unsigned LEFT_W = 9;

    localparam logic [7:0]  HDR_BYTE     = 8'h02;
    localparam logic [7:0]  FTR_BYTE     = 8'h03;
    localparam logic [7:0]  CMD_CONNECT  = 8'h26;
    localparam logic [7:0]  CMD_DATA     = 8'h44;
    localparam logic [7:0]  DOWN_CODE    = 8'h30;
    localparam logic [7:0]  CHAR_ZERO    = 8'h30;
    localparam logic [7:0]  CHAR_UPPER_A = 8'h41;
    localparam logic [15:0] INVALID_RST  = 16'hff00;

    localparam logic KIND_READING = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_COMMAND = 3'd1,
        PH_CONN    = 3'd2,
        PH_DHDR    = 3'd3,
        PH_READ    = 3'd4,
        PH_FOOTER  = 3'd5,
        PH_CHECK   = 3'd6
    } phase_t;

    // ascii hex digit to a 16-bit addend, wrapping for bytes below '0'
    function automatic logic [15:0] digit_value(input logic [7:0] b);
        logic [15:0] v;
        if (b < CHAR_UPPER_A)
        begin
            v = {8'h00, b} - {8'h00, CHAR_ZERO};
        end
        else
        begin
            v = {8'h00, b} + 16'd10 - {8'h00, CHAR_UPPER_A};
        end
        return v;
    endfunction

endpackage

// ===== design/range_sensor_frame_parser.sv =====
// top level: range sensor reply deframer with registered result output
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | in_valid, in_stall, rx_byte               | byte in
//  output  | out_valid, out_stall, result fields       | result out
//  config  | cfg_wr_en, cfg_wr_data (invalid_from)     | write only
//
//  one byte per cycle while in_stall is low; each byte updates the deframing state in the cycle it transfers
//  a result appears in the output register in the cycle after its byte
//  in_stall is raised only while a result waits and out_stall is high
//  reset returns to waiting for a header, link down, invalid_from 0xff00
`timescale 1ns / 1ps

module range_sensor_frame_parser #(
    parameter int unsigned READINGS              = rsfp_pkg::READINGS_DEF,
    parameter int unsigned DATA_HEADER_BYTES     = rsfp_pkg::DATA_HEADER_BYTES_DEF,
    parameter int unsigned CONNECT_PAYLOAD_BYTES = rsfp_pkg::CONNECT_PAYLOAD_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        result_kind,
    output logic [6:0]  reading_index,
    output logic [15:0] range_count,
    output logic        frame_type,
    output logic        checksum_ok,
    output logic        link_up,
    output logic        last,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);
    import rsfp_pkg::*;

    localparam logic [LEFT_W-1:0] READ_BYTES = LEFT_W'(READINGS * 4);
    localparam logic [LEFT_W-1:0] DHDR_BYTES = LEFT_W'(DATA_HEADER_BYTES);
    localparam logic [LEFT_W-1:0] CONN_BYTES = LEFT_W'(CONNECT_PAYLOAD_BYTES);

    phase_t            phase_reg, phase_next;
    logic [LEFT_W-1:0] left_reg, left_next;
    logic [7:0]        xor_reg, xor_next;
    logic [1:0]        digit_reg, digit_next;
    logic [15:0]       partial_reg, partial_next;
    logic [6:0]        count_reg, count_next;
    logic              data_reg, data_next;
    logic [7:0]        code_reg, code_next;
    logic              link_reg, link_next;
    logic [15:0]       invalid_reg;

    logic              out_valid_reg, out_valid_next;
    logic              kind_reg, kind_next;
    logic [6:0]        index_reg, index_next;
    logic [15:0]       range_reg, range_next;
    logic              ftype_reg, ftype_next;
    logic              ok_reg, ok_next;
    logic              emit;
    logic              in_xfer;
    logic [15:0]       digit_add;
    logic [15:0]       sum;
    logic [LEFT_W-1:0] left_dec;
    logic              ok;

    assign in_stall = out_valid_reg & out_stall;
    assign in_xfer  = in_valid & ~in_stall;

    assign digit_add = digit_value(rx_byte) << {(2'd3 - digit_reg), 2'b00};
    assign sum       = partial_reg + digit_add;
    assign left_dec  = left_reg - LEFT_W'(1);
    assign ok        = (xor_reg == rx_byte);

    always_comb
    begin
        phase_next   = phase_reg;
        left_next    = left_reg;
        xor_next     = xor_reg;
        digit_next   = digit_reg;
        partial_next = partial_reg;
        count_next   = count_reg;
        data_next    = data_reg;
        code_next    = code_reg;
        link_next    = link_reg;
        emit         = 1'b0;
        kind_next    = KIND_READING;
        index_next   = 7'd0;
        range_next   = 16'd0;
        ok_next      = 1'b0;
        unique case (phase_reg)
            PH_HEADER:
            begin
                if (rx_byte == HDR_BYTE)
                begin
                    xor_next   = rx_byte;
                    phase_next = PH_COMMAND;
                end
            end
            PH_COMMAND:
            begin
                if (rx_byte == CMD_CONNECT)
                begin
                    xor_next   = xor_reg ^ rx_byte;
                    data_next  = 1'b0;
                    phase_next = PH_CONN;
                    left_next  = CONN_BYTES;
                end
                else if (rx_byte == CMD_DATA)
                begin
                    xor_next  = xor_reg ^ rx_byte;
                    data_next = 1'b1;
                    if (DHDR_BYTES == '0)
                    begin
                        phase_next   = PH_READ;
                        left_next    = READ_BYTES;
                        digit_next   = 2'd0;
                        partial_next = 16'd0;
                        count_next   = 7'd0;
                    end
                    else
                    begin
                        phase_next = PH_DHDR;
                        left_next  = DHDR_BYTES;
                    end
                end
            end
            PH_CONN:
            begin
                xor_next  = xor_reg ^ rx_byte;
                left_next = left_dec;
                if (left_reg == CONN_BYTES)
                begin
                    code_next = rx_byte;
                end
                if (left_dec == '0)
                begin
                    phase_next = PH_FOOTER;
                end
            end
            PH_DHDR:
            begin
                xor_next  = xor_reg ^ rx_byte;
                left_next = left_dec;
                if (left_dec == '0)
                begin
                    phase_next   = PH_READ;
                    left_next    = READ_BYTES;
                    digit_next   = 2'd0;
                    partial_next = 16'd0;
                    count_next   = 7'd0;
                end
            end
            PH_READ:
            begin
                xor_next  = xor_reg ^ rx_byte;
                left_next = left_dec;
                if (digit_reg == 2'd3)
                begin
                    emit         = 1'b1;
                    index_next   = count_reg;
                    range_next   = (sum >= invalid_reg) ? 16'd0 : sum;
                    count_next   = count_reg + 7'd1;
                    partial_next = 16'd0;
                    digit_next   = 2'd0;
                end
                else
                begin
                    partial_next = sum;
                    digit_next   = digit_reg + 2'd1;
                end
                if (left_dec == '0)
                begin
                    phase_next = PH_FOOTER;
                end
            end
            PH_FOOTER:
            begin
                if (rx_byte == FTR_BYTE)
                begin
                    xor_next   = xor_reg ^ rx_byte;
                    phase_next = PH_CHECK;
                end
                else
                begin
                    xor_next   = 8'd0;
                    phase_next = PH_HEADER;
                end
            end
            PH_CHECK:
            begin
                if (ok && !data_reg)
                begin
                    link_next = (code_reg != DOWN_CODE);
                end
                emit       = 1'b1;
                kind_next  = KIND_STATUS;
                ok_next    = ok;
                xor_next   = 8'd0;
                phase_next = PH_HEADER;
            end
            default:
            begin
                xor_next   = 8'd0;
                phase_next = PH_HEADER;
            end
        endcase
        ftype_next = data_next;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg & out_stall;
        if (in_xfer && emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            left_reg      <= '0;
            xor_reg       <= 8'd0;
            digit_reg     <= 2'd0;
            partial_reg   <= 16'd0;
            count_reg     <= 7'd0;
            data_reg      <= 1'b0;
            code_reg      <= 8'd0;
            link_reg      <= 1'b0;
            invalid_reg   <= INVALID_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                invalid_reg <= cfg_wr_data;
            end
            if (in_xfer)
            begin
                phase_reg   <= phase_next;
                left_reg    <= left_next;
                xor_reg     <= xor_next;
                digit_reg   <= digit_next;
                partial_reg <= partial_next;
                count_reg   <= count_next;
                data_reg    <= data_next;
                code_reg    <= code_next;
                link_reg    <= link_next;
            end
        end
    end

    // result payload, loaded on a transfer that produces a result
    always_ff @(posedge clk)
    begin
        if (in_xfer && emit)
        begin
            kind_reg  <= kind_next;
            index_reg <= index_next;
            range_reg <= range_next;
            ftype_reg <= ftype_next;
            ok_reg    <= ok_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign result_kind   = kind_reg;
    assign reading_index = index_reg;
    assign range_count   = range_reg;
    assign frame_type    = ftype_reg;
    assign checksum_ok   = ok_reg;
    assign link_up       = link_reg;
    assign last          = kind_reg;

endmodule

// ===== design/rsfp_checker.sv =====
// checker: port-level assertions for the range sensor frame parser, with bind
`timescale 1ns / 1ps

module rsfp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic        result_kind,
    input logic [6:0]  reading_index,
    input logic [15:0] range_count,
    input logic        checksum_ok,
    input logic        last
);
    import rsfp_pkg::*;

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(range_count)
            && $stable(result_kind) && $stable(reading_index))
    else $error("stalled result changed");

    // input is held off only behind a blocked result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked result");

    // status results carry no reading
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == KIND_STATUS |-> last && reading_index == 7'd0
            && range_count == 16'd0)
    else $error("status result with reading payload");

    // readings carry no status
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == KIND_READING |-> !last && !checksum_ok)
    else $error("reading result with status payload");

endmodule

bind range_sensor_frame_parser rsfp_checker u_rsfp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .result_kind   (result_kind),
    .reading_index (reading_index),
    .range_count   (range_count),
    .checksum_ok   (checksum_ok),
    .last          (last)
);
